// File: src/spring_force_eval_assert.svh
// assertion macros for the spring force evaluator
// used by the top level; needs nothing else
`ifndef SPRING_FORCE_EVAL_ASSERT_SVH
`define SPRING_FORCE_EVAL_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define SFE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sfe assertion failed");

// consequent holds after the antecedent, delayed by the dly argument
`define SFE_ASSERT_AFTER(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(dly) (cons)) \
    else $error("sfe latency assertion failed");

`endif

// File: src/sfe_pkg.sv
// shared constants and types of the spring force evaluator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfe_pkg;

  localparam int FracBitsDef = 16;
  localparam int MagW        = 32;  // magnitude of a position difference
  localparam int RootW       = 33;  // floored length of the difference vector
  localparam int MulLat      = 4;   // cycles through one fixed-point multiplier

  typedef struct packed {
    logic             cmd;
    logic             zero;
    logic             sx;
    logic             sy;
    logic [MagW-1:0]  mx;
    logic [MagW-1:0]  my;
    logic [30:0]      rest;
    logic [30:0]      k;
    logic [31:0]      damp;
    logic [31:0]      vx;
    logic [31:0]      vy;
  } side_t;

endpackage

`default_nettype wire

// File: src/sfe_delay.sv
// fixed-length shift line that keeps side data aligned with the datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sfe_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] d_o
);

  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
  end

  for (genvar i = 1; i < N; i++) begin : g_tap
    always_ff @(posedge clk_i) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign d_o = tap_q[N-1];

endmodule

`default_nettype wire

// File: src/sfe_isqrt.sv
// pipelined floored square root, one result bit per stage
// depends on sfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfe_isqrt (
  input  wire logic                         clk_i,
  input  wire logic [2*sfe_pkg::RootW-1:0]  rad_i,
  output logic      [sfe_pkg::RootW-1:0]    root_o
);

  import sfe_pkg::*;

  localparam int RemW = RootW + 2;
  localparam int CurW = RootW + 4;

  logic [RemW-1:0]    rem_q  [RootW];
  logic [RootW-1:0]   root_q [RootW];
  logic [2*RootW-1:0] rad_q  [RootW];

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    logic [RemW-1:0]    rem_in;
    logic [RootW-1:0]   root_in;
    logic [2*RootW-1:0] rad_in;
    logic [CurW-1:0]    cur;
    logic [CurW-1:0]    trial;
    logic               ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem_in, rad_in[2*RootW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? RemW'(cur - trial) : RemW'(cur);
      root_q[i] <= {root_in[RootW-2:0], ge};
      rad_q[i]  <= {rad_in[2*RootW-3:0], 2'b00};
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

`default_nettype wire

// File: src/sfe_div.sv
// pipelined restoring divider forming one signed unit-vector component
// depends on sfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfe_div #(
  parameter int FRAC_BITS = sfe_pkg::FracBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic [sfe_pkg::MagW-1:0]    m_i,
  input  wire logic                        neg_i,
  input  wire logic [sfe_pkg::RootW-1:0]   len_i,
  output logic signed [FRAC_BITS+1:0]      q_o
);

  import sfe_pkg::*;

  // quotient never exceeds one, so it needs one integer bit
  localparam int QW = FRAC_BITS + 1;

  logic [RootW-1:0] rem_q [QW];
  logic [QW-1:0]    quo_q [QW];
  logic [RootW-1:0] len_q [QW];
  logic             neg_q [QW];
  logic signed [FRAC_BITS+1:0] q_q;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RootW-1:0] rem_in;
    logic [QW-1:0]    quo_in;
    logic [RootW-1:0] len_in;
    logic             neg_in;
    logic             bit_in;
    logic [RootW:0]   cur;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = RootW'(m_i >> 1);
      assign quo_in = '0;
      assign len_in = len_i;
      assign neg_in = neg_i;
      assign bit_in = m_i[0];
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign len_in = len_q[i-1];
      assign neg_in = neg_q[i-1];
      assign bit_in = 1'b0;
    end

    assign cur = {rem_in, bit_in};
    assign ge  = (cur >= {1'b0, len_in});

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? RootW'(cur - {1'b0, len_in}) : RootW'(cur);
      quo_q[i] <= {quo_in[QW-2:0], ge};
      len_q[i] <= len_in;
      neg_q[i] <= neg_in;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= neg_q[QW-1] ? -$signed({1'b0, quo_q[QW-1]}) : $signed({1'b0, quo_q[QW-1]});
  end

  assign q_o = q_q;

endmodule

`default_nettype wire

// File: src/sfe_fxmul.sv
// four-stage fixed-point multiply, truncated toward zero, magnitude clamped at 2^62
// depends on sfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfe_fxmul #(
  parameter int FRAC_BITS = sfe_pkg::FracBitsDef,
  parameter int BW        = 32
) (
  input  wire logic               clk_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [BW-1:0] b_i,
  output logic signed [63:0]      p_o
);

  import sfe_pkg::*;

  localparam int PW = 64 + BW;
  localparam int RW = PW - FRAC_BITS;

  logic          neg1_q, neg2_q, neg3_q;
  logic [63:0]   ma1_q;
  logic [BW-1:0] mb1_q;
  logic [31+BW:0] pl2_q, ph2_q;
  logic [PW-1:0] sum3_q;
  logic signed [63:0] p4_q;

  logic [RW-1:0] r;
  logic          over;
  logic [62:0]   mag;

  always_ff @(posedge clk_i) begin
    neg1_q <= a_i[63] ^ b_i[BW-1];
    ma1_q  <= a_i[63] ? 64'(-a_i) : 64'(a_i);
    mb1_q  <= b_i[BW-1] ? BW'(-b_i) : BW'(b_i);
  end

  // split the wide operand into two 32-bit halves
  always_ff @(posedge clk_i) begin
    neg2_q <= neg1_q;
    pl2_q  <= ma1_q[31:0] * mb1_q;
    ph2_q  <= ma1_q[63:32] * mb1_q;
  end

  always_ff @(posedge clk_i) begin
    neg3_q <= neg2_q;
    sum3_q <= {ph2_q, 32'h0} + PW'(pl2_q);
  end

  assign r    = sum3_q[PW-1:FRAC_BITS];
  assign over = (|r[RW-1:63]) || (r[62] && (|r[61:0]));
  assign mag  = over ? {1'b1, 62'h0} : r[62:0];

  always_ff @(posedge clk_i) begin
    p4_q <= neg3_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign p_o = p4_q;

endmodule

`default_nettype wire

// File: src/spring_force_eval.sv
// spring / drag force evaluator, top level
// depends on sfe_pkg, sfe_delay, sfe_isqrt, sfe_div, sfe_fxmul, spring_force_eval_assert.svh
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------------
//  command   | start / busy             | cmd, pos a/b, rest, k, damping, vel
//  result    | done_o strobe, 1 cycle   | force a/b x/y, skipped
//
// one transfer per cycle; busy stays low, the pipeline never holds
// the latency comes mostly from the square root stages, the divider stages
// and two multiplier passes
// reset clears only the valid line; results show one cycle each on done_o
`timescale 1ns / 1ps
`default_nettype none
`include "spring_force_eval_assert.svh"

module spring_force_eval #(
  parameter int FRAC_BITS = sfe_pkg::FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cmd_i,
  input  wire logic signed [31:0] pos_a_x_i,
  input  wire logic signed [31:0] pos_a_y_i,
  input  wire logic signed [31:0] pos_b_x_i,
  input  wire logic signed [31:0] pos_b_y_i,
  input  wire logic [30:0]        rest_length_i,
  input  wire logic [30:0]        stiffness_i,
  input  wire logic signed [31:0] damping_i,
  input  wire logic signed [31:0] vel_x_i,
  input  wire logic signed [31:0] vel_y_i,
  output logic                    done_o,
  output logic signed [31:0]      force_a_x_o,
  output logic signed [31:0]      force_a_y_o,
  output logic signed [31:0]      force_b_x_o,
  output logic signed [31:0]      force_b_y_o,
  output logic                    skipped_o
);

  import sfe_pkg::*;

  localparam int NW   = FRAC_BITS + 2;
  localparam int PXW  = NW + 32;
  localparam int SW   = PXW + 1;
  localparam int DotW = SW - FRAC_BITS;
  localparam int T0   = 4 + RootW;
  localparam int T1   = T0 + NW;
  localparam int Lat  = T1 + 5 + 2 * MulLat;
  localparam int SideW = $bits(side_t);
  localparam logic signed [63:0] SatMax = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SatMin = -64'sh0000_0000_8000_0000;

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] res;
    if (v > SatMax) begin
      res = 32'h7FFF_FFFF;
    end else if (v < SatMin) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  logic             take;
  logic [Lat-1:0]   vld_q;

  logic signed [32:0] dx1_q, dy1_q;
  logic             cmd1_q;
  logic [30:0]      rest1_q, k1_q;
  logic [31:0]      damp1_q, vx1_q, vy1_q;
  side_t            side2_q;
  logic [63:0]      sqx3_q, sqy3_q;
  logic [2*RootW-1:0] rad4_q;

  logic [RootW-1:0] len0;
  side_t            side0, side_t1;
  logic [SideW-1:0] side0_raw, side_t1_raw;

  logic signed [NW-1:0] nx, ny, nx_d, ny_d;
  logic signed [33:0]   fdiff_q;
  logic [30:0]          kx_q;
  logic signed [63:0]   f_t0, f_t1, f_t3, fdamp, total_q, yx, yy;

  logic signed [PXW-1:0] px_q, py_q;
  logic signed [SW-1:0]  s_q, s_adj;
  logic signed [DotW-1:0] dot_q;
  logic signed [31:0]    damp_d;
  logic                  cmd_t3;
  logic [1:0]            ctl_out;

  logic [31:0] fax_q, fay_q, fbx_q, fby_q;
  logic        skip_q;

  assign busy = 1'b0;
  assign take = start && !busy;

  // valid line follows the datapath depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], take};
    end
  end

  // difference vector
  always_ff @(posedge clk_i) begin
    dx1_q   <= {pos_a_x_i[31], pos_a_x_i} - {pos_b_x_i[31], pos_b_x_i};
    dy1_q   <= {pos_a_y_i[31], pos_a_y_i} - {pos_b_y_i[31], pos_b_y_i};
    cmd1_q  <= cmd_i;
    rest1_q <= rest_length_i;
    k1_q    <= stiffness_i;
    damp1_q <= damping_i;
    vx1_q   <= vel_x_i;
    vy1_q   <= vel_y_i;
  end

  always_ff @(posedge clk_i) begin
    side2_q.cmd  <= cmd1_q;
    side2_q.zero <= (dx1_q == '0) && (dy1_q == '0);
    side2_q.sx   <= dx1_q[32];
    side2_q.sy   <= dy1_q[32];
    side2_q.mx   <= dx1_q[32] ? MagW'(-dx1_q) : dx1_q[MagW-1:0];
    side2_q.my   <= dy1_q[32] ? MagW'(-dy1_q) : dy1_q[MagW-1:0];
    side2_q.rest <= rest1_q;
    side2_q.k    <= k1_q;
    side2_q.damp <= damp1_q;
    side2_q.vx   <= vx1_q;
    side2_q.vy   <= vy1_q;
  end

  always_ff @(posedge clk_i) begin
    sqx3_q <= side2_q.mx * side2_q.mx;
    sqy3_q <= side2_q.my * side2_q.my;
  end

  always_ff @(posedge clk_i) begin
    rad4_q <= (2*RootW)'(sqx3_q) + (2*RootW)'(sqy3_q);
  end

  sfe_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rad_i  (rad4_q),
    .root_o (len0)
  );

  sfe_delay #(.W(SideW), .N(RootW + 2)) u_dly_side0 (
    .clk_i (clk_i),
    .d_i   (side2_q),
    .d_o   (side0_raw)
  );
  assign side0 = side_t'(side0_raw);

  sfe_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i (clk_i),
    .m_i   (side0.mx),
    .neg_i (side0.sx),
    .len_i (len0),
    .q_o   (nx)
  );

  sfe_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i (clk_i),
    .m_i   (side0.my),
    .neg_i (side0.sy),
    .len_i (len0),
    .q_o   (ny)
  );

  // spring term: k * (rest - len) is the hooke force, minus k times the stretch
  always_ff @(posedge clk_i) begin
    fdiff_q <= 34'(side0.rest) - 34'(len0);
    kx_q    <= side0.k;
  end

  sfe_fxmul #(.FRAC_BITS(FRAC_BITS), .BW(32)) u_mul_k (
    .clk_i (clk_i),
    .a_i   ({{30{fdiff_q[33]}}, fdiff_q}),
    .b_i   ({1'b0, kx_q}),
    .p_o   (f_t0)
  );

  sfe_delay #(.W(64), .N(NW - 1 - MulLat)) u_dly_f1 (
    .clk_i (clk_i),
    .d_i   (f_t0),
    .d_o   (f_t1)
  );

  sfe_delay #(.W(SideW), .N(NW)) u_dly_side1 (
    .clk_i (clk_i),
    .d_i   (side0),
    .d_o   (side_t1_raw)
  );
  assign side_t1 = side_t'(side_t1_raw);

  // damping: v . n summed at full width, then shifted toward zero
  always_ff @(posedge clk_i) begin
    px_q <= $signed(side_t1.vx) * nx;
    py_q <= $signed(side_t1.vy) * ny;
  end

  always_ff @(posedge clk_i) begin
    s_q <= px_q + py_q;
  end

  assign s_adj = s_q + $signed({{(SW - FRAC_BITS){1'b0}}, {FRAC_BITS{s_q[SW-1]}}});

  always_ff @(posedge clk_i) begin
    dot_q <= DotW'(s_adj >>> FRAC_BITS);
  end

  sfe_delay #(.W(32), .N(3)) u_dly_damp (
    .clk_i (clk_i),
    .d_i   (side_t1.damp),
    .d_o   (damp_d)
  );

  sfe_fxmul #(.FRAC_BITS(FRAC_BITS), .BW(32)) u_mul_damp (
    .clk_i (clk_i),
    .a_i   ({{(64 - DotW){dot_q[DotW-1]}}, dot_q}),
    .b_i   (damp_d),
    .p_o   (fdamp)
  );

  sfe_delay #(.W(65), .N(3 + MulLat)) u_dly_f3 (
    .clk_i (clk_i),
    .d_i   ({side_t1.cmd, f_t1}),
    .d_o   ({cmd_t3, f_t3})
  );

  always_ff @(posedge clk_i) begin
    total_q <= cmd_t3 ? f_t3 + fdamp : f_t3;
  end

  sfe_delay #(.W(2 * NW), .N(4 + MulLat)) u_dly_n (
    .clk_i (clk_i),
    .d_i   ({nx, ny}),
    .d_o   ({nx_d, ny_d})
  );

  sfe_fxmul #(.FRAC_BITS(FRAC_BITS), .BW(NW)) u_mul_x (
    .clk_i (clk_i),
    .a_i   (total_q),
    .b_i   (nx_d),
    .p_o   (yx)
  );

  sfe_fxmul #(.FRAC_BITS(FRAC_BITS), .BW(NW)) u_mul_y (
    .clk_i (clk_i),
    .a_i   (total_q),
    .b_i   (ny_d),
    .p_o   (yy)
  );

  sfe_delay #(.W(2), .N(4 + 2 * MulLat)) u_dly_ctl (
    .clk_i (clk_i),
    .d_i   ({side_t1.cmd, side_t1.zero}),
    .d_o   (ctl_out)
  );

  // drag mode leaves end a at zero; coincident points zero everything
  always_ff @(posedge clk_i) begin
    fax_q  <= (ctl_out[1] || ctl_out[0]) ? 32'h0 : sat32(yx);
    fay_q  <= (ctl_out[1] || ctl_out[0]) ? 32'h0 : sat32(yy);
    fbx_q  <= ctl_out[0] ? 32'h0 : sat32(-yx);
    fby_q  <= ctl_out[0] ? 32'h0 : sat32(-yy);
    skip_q <= ctl_out[0];
  end

  assign done_o      = vld_q[Lat-1];
  assign force_a_x_o = fax_q;
  assign force_a_y_o = fay_q;
  assign force_b_x_o = fbx_q;
  assign force_b_y_o = fby_q;
  assign skipped_o   = skip_q;

  `SFE_ASSERT_IMPLY(a_skip_zero, clk_i, rst_ni, done_o && skipped_o, (force_a_x_o == '0) && (force_a_y_o == '0) && (force_b_x_o == '0) && (force_b_y_o == '0))
  `SFE_ASSERT_AFTER(a_lat, clk_i, rst_ni, take, Lat, done_o)
  `SFE_ASSERT_IMPLY(a_no_spurious, clk_i, rst_ni, done_o, $past(take, Lat))

endmodule

`default_nettype wire
